// ===== src/slp_pkg.sv =====
// Package for the sample playback looper: item kind codes, register indexes
// and the status record passed down the result pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slp_pkg;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_PLAY   = 3'd1;
   localparam logic [2:0] KIND_STOP   = 3'd2;
   localparam logic [2:0] KIND_PAUSE  = 3'd3;
   localparam logic [2:0] KIND_RESUME = 3'd4;
   localparam logic [2:0] KIND_SETPOS = 3'd5;
   localparam logic [2:0] KIND_LOAD   = 3'd6;

   localparam logic [2:0] REG_RANGE_START = 3'd0;
   localparam logic [2:0] REG_RANGE_STOP  = 3'd1;
   localparam logic [2:0] REG_LOOP_ENABLE = 3'd2;
   localparam logic [2:0] REG_LOOP_LIMIT  = 3'd3;
   localparam logic [2:0] REG_DATA_LENGTH = 3'd4;

   localparam int POS_W   = 18;
   localparam int RANGE_W = 17;
   localparam int LIMIT_W = 16;
   localparam int SMP_W   = 16;

   // Result status that travels alongside the store read.
   typedef struct packed {
      logic rd;       // sample comes from the store, otherwise silence
      logic looped;
      logic done;
      logic playing;
   } stat_type;

endpackage
`default_nettype wire

// ===== src/slp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the sample store of the playback looper.
`timescale 1ns / 1ps
`default_nettype none
module slp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== src/sample_playback_looper.sv =====
// Sample player with a loop range. A transaction accepted at an edge has its store
// read issued at the accepting edge (stage 1), then its result is captured in the
// output register and shown on rsp. Throughput: one item per cycle while rsp_tready
// does not stall the output, set by the single read port of the sample store;
// req_tready falls only while both stages hold a stalled result.
// Reset clears position, pass count, run flag, pipeline and registers but loop enable,
// which it sets; the sample store is not cleared and holds undefined data until loaded.
`timescale 1ns / 1ps
`default_nettype none
module sample_playback_looper #(
   parameter int STORE_DEPTH = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // index[15:0], sample_in[31:16]
   input  wire logic [2:0]  req_tuser,   // kind[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // sample_out[15:0]
   output logic [2:0]       rsp_tuser,   // looped[0], done_res[1], playing[2]
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [16:0] csr_wdata
);

   localparam int AW = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [slp_pkg::RANGE_W-1:0] start_ff, stop_ff, length_ff;
   logic                        loop_en_ff;
   logic [slp_pkg::LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         stop_ff    <= '0;
         loop_en_ff <= 1'b1;
         limit_ff   <= '0;
         length_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            slp_pkg::REG_RANGE_START: start_ff   <= csr_wdata;
            slp_pkg::REG_RANGE_STOP:  stop_ff    <= csr_wdata;
            slp_pkg::REG_LOOP_ENABLE: loop_en_ff <= csr_wdata[0];
            slp_pkg::REG_LOOP_LIMIT:  limit_ff   <= csr_wdata[15:0];
            slp_pkg::REG_DATA_LENGTH: length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Player state.
   logic [slp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [slp_pkg::LIMIT_W-1:0] pass_ff, pass_in;
   logic                        run_ff, run_in;

   // Pipeline: stage 1 waits on the store read, stage 2 is the output register.
   logic                        s1_valid_ff;
   slp_pkg::stat_type           s1_stat_ff, stat_in;
   logic                        out_valid_ff;
   logic [slp_pkg::SMP_W-1:0]   out_smp_ff;
   logic [2:0]                  out_flags_ff;

   logic                        out_take, accept;
   logic [2:0]                  kind;
   logic [15:0]                 idx;
   logic [15:0]                 word;
   logic [slp_pkg::POS_W-1:0]   start_x, stop_x, pos_cl, rd_pos;
   logic [slp_pkg::LIMIT_W:0]   pass_inc;
   logic                        silent, wrap_ok, in_data;
   logic                        load_we;
   logic [AW-1:0]               waddr, raddr;
   logic [slp_pkg::SMP_W-1:0]   rdata;

   assign out_take   = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_take;
   assign accept     = req_tvalid && req_tready;

   assign kind = req_tuser;
   assign idx  = req_tdata[15:0];
   assign word = req_tdata[31:16];

   assign start_x  = {1'b0, start_ff};
   assign stop_x   = {1'b0, stop_ff};
   assign pass_inc = {1'b0, pass_ff} + 17'd1;
   assign silent   = !run_ff || (start_ff >= stop_ff) || (length_ff == '0);
   assign wrap_ok  = loop_en_ff && ((limit_ff == '0) || (pass_inc < {1'b0, limit_ff}));

   always_comb begin
      pos_in  = pos_ff;
      pass_in = pass_ff;
      run_in  = run_ff;
      stat_in = '0;
      rd_pos  = pos_ff;
      pos_cl  = (pos_ff < start_x) ? start_x : pos_ff;
      case (kind)
         slp_pkg::KIND_TICK: begin
            if (silent) begin
               stat_in.done = !loop_en_ff;
            end else if (pos_cl >= stop_x && !wrap_ok) begin
               // Range end without a permitted wrap: finish; position holds.
               stat_in.done = 1'b1;
               run_in       = 1'b0;
               pos_in       = pos_cl;
            end else begin
               if (pos_cl >= stop_x) begin
                  rd_pos         = start_x;
                  stat_in.looped = 1'b1;
                  pass_in        = pass_inc[slp_pkg::LIMIT_W-1:0];
               end else begin
                  rd_pos = pos_cl;
               end
               stat_in.rd = 1'b1;
               pos_in     = rd_pos + 18'd1;
            end
         end
         slp_pkg::KIND_PLAY: begin
            run_in  = 1'b1;
            pos_in  = start_x;
            pass_in = '0;
         end
         slp_pkg::KIND_STOP: begin
            run_in  = 1'b0;
            pos_in  = start_x;
            pass_in = '0;
         end
         slp_pkg::KIND_PAUSE:  run_in = 1'b0;
         slp_pkg::KIND_RESUME: run_in = 1'b1;
         slp_pkg::KIND_SETPOS: pos_in = {2'b00, idx};
         default: ;
      endcase
      stat_in.playing = run_in;
   end

   // Positions outside the loaded data or the store read as silence.
   assign in_data = ({1'b0, rd_pos} < {2'b00, length_ff}) && (32'(rd_pos) < STORE_DEPTH);
   assign load_we = accept && (kind == slp_pkg::KIND_LOAD) && (32'(idx) < STORE_DEPTH);
   assign waddr   = AW'(idx);
   assign raddr   = AW'(rd_pos);

   slp_ram #(
      .WIDTH (slp_pkg::SMP_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (load_we),
      .waddr (waddr),
      .wdata (word),
      .re    (accept && stat_in.rd && in_data),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pass_ff      <= '0;
         run_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            pass_ff <= pass_in;
            run_ff  <= run_in;
         end
         if (req_tready) begin
            s1_valid_ff <= accept;
         end
         if (out_take) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= {stat_in.rd && in_data, stat_in.looped, stat_in.done,
                        stat_in.playing};
      end
      if (out_take && s1_valid_ff) begin
         out_smp_ff   <= s1_stat_ff.rd ? rdata : '0;
         out_flags_ff <= {s1_stat_ff.playing, s1_stat_ff.done, s1_stat_ff.looped};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_smp_ff;
   assign rsp_tuser  = out_flags_ff;

endmodule
`default_nettype wire

// ===== src/slp_checker.sv =====
// Port-level checker for the sample playback looper, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none
module slp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp transaction changed");

   // A tick either wraps or finishes, never both.
   a_loop_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("looped and done_res both set");

   // A wrap happens only while playing.
   a_loop_play: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2])
      else $error("looped without playing");

   // Audible output comes only from a running player that has not finished.
   a_sound_play: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata != 16'd0) |-> rsp_tuser[2] && !rsp_tuser[1])
      else $error("sample played while stopped or done");

   // Reset empties the result pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind sample_playback_looper slp_checker u_slp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
